// ----- src/fcm_pkg.sv -----
// Shared types and codes for the FAT cluster chain manager.
// Holds the beat payload structs and the controller-to-datapath command
// and status structs; depends on nothing else.
`default_nettype none

package fcm_pkg;

  localparam logic [15:0] EOC_CODE  = 16'hFFFF;
  localparam logic [15:0] FREE_CODE = 16'hFFFE;

  localparam logic [1:0] REQ_REWRITE = 2'd0;
  localparam logic [1:0] REQ_FREE    = 2'd1;
  localparam logic [1:0] REQ_NEXT    = 2'd2;
  localparam logic [1:0] REQ_NONE    = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [15:0] chain_head;
    logic [19:0] byte_count;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] cluster;
    logic [10:0] clusters_linked;
  } out_t;

  typedef enum logic [3:0] {
    OP_IDLE,
    OP_CLEAR,
    OP_LOAD,
    OP_WALK_RD,
    OP_WALK_CHK,
    OP_ALLOC,
    OP_SCAN,
    OP_LINK,
    OP_ROLL,
    OP_NEXT_RD,
    OP_NEXT_CHK,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    RES_EMPTY,
    RES_BAD,
    RES_FREED,
    RES_CHAIN,
    RES_NO_SPACE,
    RES_NEXT
  } res_e;

  typedef struct packed {
    op_e  op;
    res_e res;
  } cmd_t;

  typedef struct packed {
    logic [1:0] req_type;
    logic       head_bad;
    logic       head_eoc;
    logic       bytes_zero;
    logic       walk_go;
    logic       rdata_free;
    logic       found;
    logic       scan_full;
    logic       rem_last;
    logic       clr_last;
  } sts_t;

endpackage

`default_nettype wire

// ----- src/fat_cluster_chain_manager.sv -----
// Top level of the FAT cluster chain manager: request and result beats over
// valid/ready, built from fcm_ctrl and fcm_dp; uses fcm_pkg.
//
// The block keeps a file allocation table of CLUSTER_COUNT 16-bit links in a
// single RAM with one write and one registered read per cycle. After reset it
// clears the table and takes no request meanwhile. A request is handled
// alone: a next-link read fetches the link of the chain head, a chain free
// walks the chain and frees each cluster, and a rewrite frees the old chain
// the same way, then scans for free entries at one table entry per cycle
// between links and links each free entry it finds; a full table adds a free
// walk of the partial chain. A finished result sits in an output register,
// so the next request is taken while it waits.
`default_nettype none

module fat_cluster_chain_manager #(
  parameter int unsigned CLUSTER_COUNT = 1024,
  parameter int unsigned CLUSTER_BYTES = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fcm_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fcm_pkg::out_t out_data_o
);

  import fcm_pkg::*;

  cmd_t cmd;
  sts_t sts;

  fcm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fcm_dp #(
    .CLUSTER_COUNT(CLUSTER_COUNT),
    .CLUSTER_BYTES(CLUSTER_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_data_i (in_data_i),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .out_data_o(out_data_o)
  );

endmodule

`default_nettype wire

// ----- src/fcm_ram.sv -----
// Generic simple dual-port RAM with one write port and a registered read.
// Used for the cluster link table; depends on nothing else.
`default_nettype none

module fcm_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- src/fcm_ctrl.sv -----
// Request sequencer of the FAT cluster chain manager.
// Steps through clear, walk, scan, link and reply phases; uses fcm_pkg.
`default_nettype none

module fcm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  fcm_pkg::sts_t sts_i,
  output fcm_pkg::cmd_t cmd_o
);

  import fcm_pkg::*;

  localparam logic [3:0] S_CLEAR    = 4'd0;
  localparam logic [3:0] S_IDLE     = 4'd1;
  localparam logic [3:0] S_DECODE   = 4'd2;
  localparam logic [3:0] S_WALK_RD  = 4'd3;
  localparam logic [3:0] S_WALK_CHK = 4'd4;
  localparam logic [3:0] S_WALK_END = 4'd5;
  localparam logic [3:0] S_ALLOC    = 4'd6;
  localparam logic [3:0] S_SCAN     = 4'd7;
  localparam logic [3:0] S_LINK     = 4'd8;
  localparam logic [3:0] S_ROLL     = 4'd9;
  localparam logic [3:0] S_NEXT_RD  = 4'd10;
  localparam logic [3:0] S_NEXT_CHK = 4'd11;
  localparam logic [3:0] S_DONE     = 4'd12;

  localparam logic [1:0] PH_OLD  = 2'd0;
  localparam logic [1:0] PH_FREE = 2'd1;
  localparam logic [1:0] PH_ROLL = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] phase_q, phase_d;
  res_e       res_q, res_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    cmd_o.op    = OP_IDLE;
    cmd_o.res   = res_q;
    case (state_q)
      S_CLEAR: begin
        cmd_o.op = OP_CLEAR;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts_i.req_type == REQ_NONE) begin
          res_d   = RES_EMPTY;
          state_d = S_DONE;
        end else if (sts_i.head_bad) begin
          res_d   = RES_BAD;
          state_d = S_DONE;
        end else if (sts_i.req_type == REQ_REWRITE) begin
          phase_d = PH_OLD;
          state_d = S_WALK_RD;
        end else if (sts_i.req_type == REQ_FREE) begin
          phase_d = PH_FREE;
          state_d = S_WALK_RD;
        end else if (sts_i.head_eoc) begin
          res_d   = RES_EMPTY;
          state_d = S_DONE;
        end else begin
          state_d = S_NEXT_RD;
        end
      end
      S_WALK_RD: begin
        cmd_o.op = OP_WALK_RD;
        state_d  = sts_i.walk_go ? S_WALK_CHK : S_WALK_END;
      end
      S_WALK_CHK: begin
        cmd_o.op = OP_WALK_CHK;
        state_d  = sts_i.rdata_free ? S_WALK_END : S_WALK_RD;
      end
      S_WALK_END: begin
        case (phase_q)
          PH_FREE: begin
            res_d   = RES_FREED;
            state_d = S_DONE;
          end
          PH_ROLL: begin
            res_d   = RES_NO_SPACE;
            state_d = S_DONE;
          end
          default: begin
            state_d = S_ALLOC;
          end
        endcase
      end
      S_ALLOC: begin
        cmd_o.op = OP_ALLOC;
        if (sts_i.bytes_zero) begin
          res_d   = RES_CHAIN;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (sts_i.found) begin
          state_d = S_LINK;
        end else if (sts_i.scan_full) begin
          state_d = S_ROLL;
        end
      end
      S_LINK: begin
        cmd_o.op = OP_LINK;
        if (sts_i.rem_last) begin
          res_d   = RES_CHAIN;
          state_d = S_DONE;
        end else begin
          state_d = S_SCAN;
        end
      end
      S_ROLL: begin
        cmd_o.op = OP_ROLL;
        phase_d  = PH_ROLL;
        state_d  = S_WALK_RD;
      end
      S_NEXT_RD: begin
        cmd_o.op = OP_NEXT_RD;
        state_d  = S_NEXT_CHK;
      end
      S_NEXT_CHK: begin
        cmd_o.op = OP_NEXT_CHK;
        res_d    = RES_NEXT;
        state_d  = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.op    = OP_EMIT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      phase_q     <= PH_OLD;
      res_q       <= RES_EMPTY;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      res_q       <= res_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ----- src/fcm_dp.sv -----
// Datapath of the FAT cluster chain manager: link table RAM, walk pointer,
// scan cursor, chain head and tail, byte and cluster counters, result beat.
// Uses fcm_pkg and fcm_ram.
`default_nettype none

module fcm_dp #(
  parameter int unsigned CLUSTER_COUNT = 1024,
  parameter int unsigned CLUSTER_BYTES = 512
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fcm_pkg::in_t  in_data_i,
  input  fcm_pkg::cmd_t cmd_i,
  output fcm_pkg::sts_t sts_o,
  output fcm_pkg::out_t out_data_o
);

  import fcm_pkg::*;

  localparam int unsigned CW           = $clog2(CLUSTER_COUNT);
  localparam logic [15:0] CountLink    = 16'(CLUSTER_COUNT);
  localparam logic [CW:0] CountIdx     = (CW+1)'(CLUSTER_COUNT);
  localparam logic [CW-1:0] LastIdx    = CW'(CLUSTER_COUNT - 1);
  localparam logic [19:0] ClusterBytes = 20'(CLUSTER_BYTES);

  in_t         req_q, req_d;
  out_t        out_q, out_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] first_q, first_d;
  logic [15:0] prev_q, prev_d;
  logic [19:0] rem_q, rem_d;
  logic [CW:0] cnt_q, cnt_d;
  logic [CW:0] iss_q, iss_d;
  logic [CW-1:0] chk_q, chk_d;
  logic [CW-1:0] clr_q, clr_d;
  logic        pend_q, pend_d;

  logic          ram_we;
  logic [CW-1:0] ram_waddr;
  logic [15:0]   ram_wdata;
  logic          ram_re;
  logic [CW-1:0] ram_raddr;
  logic [15:0]   ram_rdata;

  logic rdata_free;
  logic walk_go;
  logic found;
  logic rem_last;

  fcm_ram #(
    .WIDTH(16),
    .DEPTH(CLUSTER_COUNT)
  ) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rdata_free = (ram_rdata == FREE_CODE);
  assign walk_go    = (cur_q < CountLink) && (cnt_q < CountIdx);
  assign found      = pend_q && rdata_free;
  assign rem_last   = (rem_q <= ClusterBytes);

  always_comb begin
    sts_o.req_type   = req_q.req_type;
    sts_o.head_bad   = (req_q.chain_head != EOC_CODE) && (req_q.chain_head >= CountLink);
    sts_o.head_eoc   = (req_q.chain_head == EOC_CODE);
    sts_o.bytes_zero = (req_q.byte_count == 20'd0);
    sts_o.walk_go    = walk_go;
    sts_o.rdata_free = rdata_free;
    sts_o.found      = found;
    sts_o.scan_full  = !pend_q && (iss_q == CountIdx);
    sts_o.rem_last   = rem_last;
    sts_o.clr_last   = (clr_q == LastIdx);
  end

  always_comb begin
    req_d     = req_q;
    out_d     = out_q;
    cur_d     = cur_q;
    first_d   = first_q;
    prev_d    = prev_q;
    rem_d     = rem_q;
    cnt_d     = cnt_q;
    iss_d     = iss_q;
    chk_d     = chk_q;
    clr_d     = clr_q;
    pend_d    = pend_q;
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = FREE_CODE;
    ram_re    = 1'b0;
    ram_raddr = '0;
    case (cmd_i.op)
      OP_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = FREE_CODE;
        clr_d     = clr_q + 1'b1;
      end
      OP_LOAD: begin
        req_d = in_data_i;
        cur_d = in_data_i.chain_head;
        cnt_d = '0;
      end
      OP_WALK_RD: begin
        ram_re    = walk_go;
        ram_raddr = cur_q[CW-1:0];
      end
      OP_WALK_CHK: begin
        if (!rdata_free) begin
          ram_we    = 1'b1;
          ram_waddr = cur_q[CW-1:0];
          ram_wdata = FREE_CODE;
          cnt_d     = cnt_q + 1'b1;
          cur_d     = ram_rdata;
        end
      end
      OP_ALLOC: begin
        first_d = EOC_CODE;
        prev_d  = EOC_CODE;
        rem_d   = req_q.byte_count;
        iss_d   = '0;
        pend_d  = 1'b0;
        cnt_d   = '0;
      end
      OP_SCAN: begin
        if (found) begin
          ram_we    = 1'b1;
          ram_waddr = chk_q;
          ram_wdata = EOC_CODE;
          if (first_q == EOC_CODE) begin
            first_d = 16'(chk_q);
          end
          iss_d  = (CW+1)'(chk_q) + 1'b1;
          pend_d = 1'b0;
        end else if (iss_q < CountIdx) begin
          ram_re    = 1'b1;
          ram_raddr = iss_q[CW-1:0];
          chk_d     = iss_q[CW-1:0];
          iss_d     = iss_q + 1'b1;
          pend_d    = 1'b1;
        end else begin
          pend_d = 1'b0;
        end
      end
      OP_LINK: begin
        if (prev_q != EOC_CODE) begin
          ram_we    = 1'b1;
          ram_waddr = prev_q[CW-1:0];
          ram_wdata = 16'(chk_q);
        end
        prev_d = 16'(chk_q);
        cnt_d  = cnt_q + 1'b1;
        rem_d  = rem_last ? 20'd0 : (rem_q - ClusterBytes);
      end
      OP_ROLL: begin
        cur_d = first_q;
        cnt_d = '0;
      end
      OP_NEXT_RD: begin
        ram_re    = 1'b1;
        ram_raddr = req_q.chain_head[CW-1:0];
      end
      OP_NEXT_CHK: begin
        cur_d = ram_rdata;
      end
      OP_EMIT: begin
        out_d.status          = ST_OK;
        out_d.cluster         = EOC_CODE;
        out_d.clusters_linked = '0;
        case (cmd_i.res)
          RES_BAD: begin
            out_d.status = ST_RANGE;
          end
          RES_FREED: begin
            out_d.clusters_linked = 11'(cnt_q);
          end
          RES_CHAIN: begin
            out_d.cluster         = first_q;
            out_d.clusters_linked = 11'(cnt_q);
          end
          RES_NO_SPACE: begin
            out_d.status = ST_NO_SPACE;
          end
          RES_NEXT: begin
            out_d.cluster = cur_q;
          end
          default: begin
            out_d.status = ST_OK;
          end
        endcase
      end
      default: begin
        pend_d = pend_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q  <= '0;
      pend_q <= 1'b0;
      iss_q  <= '0;
      cnt_q  <= '0;
    end else begin
      clr_q  <= clr_d;
      pend_q <= pend_d;
      iss_q  <= iss_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    out_q   <= out_d;
    cur_q   <= cur_d;
    first_q <= first_d;
    prev_q  <= prev_d;
    rem_q   <= rem_d;
    chk_q   <= chk_d;
  end

  assign out_data_o = out_q;

  // A chain walk only ever frees an entry inside the table.
  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_WALK_CHK) |-> (cur_q < CountLink))
    else $error("walk frees an entry outside the table");

  // The scan cursor only moves forward, so a new tail lies above the old one.
  a_link_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == OP_LINK) && (prev_q != EOC_CODE)) |-> (prev_q < 16'(chk_q)))
    else $error("chain link does not point forward");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CountIdx)
    else $error("cluster count exceeds table size");

  a_iss_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iss_q <= CountIdx)
    else $error("scan cursor runs past the table");

  a_found_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((cmd_i.op == OP_SCAN) && found) |-> ((CW+1)'(chk_q) < CountIdx))
    else $error("allocated cluster outside the table");

endmodule

`default_nettype wire
